>>> rtl/core/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants of the LRU key-value cache
// Payload structs, store control struct, opcodes and register map.
// ----------------------------------------------------------------------------
package lkv_pkg;

    // Default number of cache slots
    localparam int LKV_ENTRIES = 16;

    // Field widths
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-3:0] REG_CAPACITY = '0;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Request item
    typedef struct packed {
        logic                    op;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } req_item_t;

    // Result item
    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] value_out;
    } rsp_item_t;

    // Control from sequencer to slot store
    typedef struct packed {
        logic rd_en;
        logic key_we;
        logic value_we;
        logic rank_we;
        logic valid_set;
        logic valid_clr;
    } store_ctl_t;

endpackage

>>> rtl/core/lkv_store.sv
// ----------------------------------------------------------------------------
// lkv_store: slot storage of the LRU key-value cache
// Key, value and age-rank memories with one registered read port and one
// write port; per-slot valid flops cleared at reset.
// ----------------------------------------------------------------------------
module lkv_store #(
    parameter int ENTRIES = lkv_pkg::LKV_ENTRIES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lkv_pkg::store_ctl_t         ctl,
    input  logic [$clog2(ENTRIES)-1:0]  rd_addr,
    input  logic [$clog2(ENTRIES)-1:0]  wr_addr,
    input  logic [lkv_pkg::KEY_W-1:0]   wr_key,
    input  logic [lkv_pkg::VAL_W-1:0]   wr_value,
    input  logic [$clog2(ENTRIES)-1:0]  wr_rank,
    output logic [lkv_pkg::KEY_W-1:0]   rd_key,
    output logic [lkv_pkg::VAL_W-1:0]   rd_value,
    output logic [$clog2(ENTRIES)-1:0]  rd_rank,
    output logic                        rd_valid
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic [lkv_pkg::KEY_W-1:0] key_mem   [ENTRIES];
    logic [lkv_pkg::VAL_W-1:0] value_mem [ENTRIES];
    logic [IDX_W-1:0]          rank_mem  [ENTRIES];

    logic [ENTRIES-1:0]        valid_reg;
    logic [lkv_pkg::KEY_W-1:0] rd_key_reg;
    logic [lkv_pkg::VAL_W-1:0] rd_value_reg;
    logic [IDX_W-1:0]          rd_rank_reg;
    logic                      rd_valid_reg;

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (ctl.key_we)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (ctl.value_we)
        begin
            value_mem[wr_addr] <= wr_value;
        end
        if (ctl.rank_we)
        begin
            rank_mem[wr_addr] <= wr_rank;
        end
        if (ctl.rd_en)
        begin
            rd_key_reg   <= key_mem[rd_addr];
            rd_value_reg <= value_mem[rd_addr];
            rd_rank_reg  <= rank_mem[rd_addr];
        end
    end

    // Valid flops, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.valid_set)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            else if (ctl.valid_clr)
            begin
                valid_reg[wr_addr] <= 1'b0;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_key   = rd_key_reg;
    assign rd_value = rd_value_reg;
    assign rd_rank  = rd_rank_reg;
    assign rd_valid = rd_valid_reg;

endmodule

>>> rtl/core/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl: sequencer of the LRU key-value cache
// Scans all slots with one key comparator to find the hit and free slots;
// unless a get missed, sweeps them again to age ranks, evict and insert.
// ----------------------------------------------------------------------------
module lkv_ctrl #(
    parameter int ENTRIES = lkv_pkg::LKV_ENTRIES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lkv_pkg::CAP_W-1:0]   capacity,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  lkv_pkg::req_item_t          item,
    output logic                        res_valid,
    input  logic                        res_ready,
    output lkv_pkg::rsp_item_t          res,
    output lkv_pkg::store_ctl_t         ctl,
    output logic [$clog2(ENTRIES)-1:0]  rd_addr,
    output logic [$clog2(ENTRIES)-1:0]  wr_addr,
    output logic [lkv_pkg::KEY_W-1:0]   wr_key,
    output logic [lkv_pkg::VAL_W-1:0]   wr_value,
    output logic [$clog2(ENTRIES)-1:0]  wr_rank,
    input  logic [lkv_pkg::KEY_W-1:0]   rd_key,
    input  logic [lkv_pkg::VAL_W-1:0]   rd_value,
    input  logic [$clog2(ENTRIES)-1:0]  rd_rank,
    input  logic                        rd_valid
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ENTRIES);
    localparam logic [CMP_W-1:0] CAP_MAX = CMP_W'(ENTRIES);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic                      op_reg, op_next;
    logic [lkv_pkg::KEY_W-1:0] key_reg, key_next;
    logic [lkv_pkg::VAL_W-1:0] value_reg, value_next;
    logic                      evict_reg, evict_next;
    logic [IDX_W-1:0]          evict_rank_reg, evict_rank_next;
    logic [CNT_W-1:0]          cap_eff_reg, cap_eff_next;
    logic [CNT_W-1:0]          used_reg, used_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      pend_reg, pend_next;
    logic [IDX_W-1:0]          pend_idx_reg, pend_idx_next;
    logic                      found_reg, found_next;
    logic [IDX_W-1:0]          hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]          hit_rank_reg, hit_rank_next;
    logic [lkv_pkg::VAL_W-1:0] hit_value_reg, hit_value_next;
    logic                      free_found_reg, free_found_next;
    logic [IDX_W-1:0]          free_idx_reg, free_idx_next;

    logic [CMP_W-1:0] cap_ext;
    logic [CNT_W-1:0] cap_eff;
    logic             key_match;
    logic             rank_below_hit;
    logic             rank_old;
    logic [IDX_W-1:0] rank_inc;
    logic             scan_more;

    // Effective capacity: zero counts as one, saturate at slot count
    always_comb
    begin
        cap_ext = CMP_W'(capacity);
        if (cap_ext == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (cap_ext > CAP_MAX)
        begin
            cap_eff = CNT_END;
        end
        else
        begin
            cap_eff = CNT_W'(cap_ext);
        end
    end

    // Shared comparator and rank arithmetic on the read slot
    assign key_match      = rd_valid && (rd_key == key_reg);
    assign rank_below_hit = rd_rank < hit_rank_reg;
    assign rank_old       = rd_rank >= evict_rank_reg;
    assign rank_inc       = rd_rank + IDX_W'(1);
    assign scan_more      = cnt_reg != CNT_END;

    assign item_ready = state_reg == ST_IDLE;
    assign res_valid  = state_reg == ST_RESULT;
    assign res.hit       = found_reg;
    assign res.value_out = found_reg ? hit_value_reg : '0;

    assign rd_addr  = cnt_reg[IDX_W-1:0];
    assign wr_addr  = pend_idx_reg;
    assign wr_key   = key_reg;
    assign wr_value = value_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        evict_next      = evict_reg;
        evict_rank_next = evict_rank_reg;
        cap_eff_next    = cap_eff_reg;
        used_next       = used_reg;
        cnt_next        = cnt_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rank_next   = hit_rank_reg;
        hit_value_next  = hit_value_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        ctl             = '0;
        wr_rank         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    op_next         = item.op;
                    key_next        = item.key;
                    value_next      = item.value;
                    cap_eff_next    = cap_eff;
                    evict_next      = used_reg >= cap_eff;
                    evict_rank_next = IDX_W'(cap_eff - CNT_W'(1));
                    cnt_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue reads
                if (scan_more)
                begin
                    ctl.rd_en     = 1'b1;
                    cnt_next      = cnt_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = cnt_reg[IDX_W-1:0];
                end
                // Check returned slot
                if (pend_reg)
                begin
                    if (key_match && !found_reg)
                    begin
                        found_next     = 1'b1;
                        hit_idx_next   = pend_idx_reg;
                        hit_rank_next  = rd_rank;
                        hit_value_next = rd_value;
                    end
                    if (!free_found_reg && (!rd_valid || (evict_reg && rank_old)))
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = pend_idx_reg;
                    end
                end
                if (!scan_more && !pend_reg)
                begin
                    cnt_next = '0;
                    if (op_reg == lkv_pkg::OP_GET && !found_reg)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end

            ST_UPDATE:
            begin
                if (scan_more)
                begin
                    ctl.rd_en     = 1'b1;
                    cnt_next      = cnt_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = cnt_reg[IDX_W-1:0];
                end
                // Rewrite the returned slot
                if (pend_reg)
                begin
                    if (found_reg)
                    begin
                        // Touch: hit slot becomes most recent
                        if (pend_idx_reg == hit_idx_reg)
                        begin
                            ctl.rank_we  = 1'b1;
                            ctl.value_we = op_reg == lkv_pkg::OP_PUT;
                        end
                        else if (rd_valid && rank_below_hit)
                        begin
                            ctl.rank_we = 1'b1;
                            wr_rank     = rank_inc;
                        end
                    end
                    else
                    begin
                        // Insert: evict oldest, age the rest, fill free slot
                        if (pend_idx_reg == free_idx_reg)
                        begin
                            ctl.key_we    = 1'b1;
                            ctl.value_we  = 1'b1;
                            ctl.rank_we   = 1'b1;
                            ctl.valid_set = 1'b1;
                        end
                        else if (rd_valid && evict_reg && rank_old)
                        begin
                            ctl.valid_clr = 1'b1;
                        end
                        else if (rd_valid)
                        begin
                            ctl.rank_we = 1'b1;
                            wr_rank     = rank_inc;
                        end
                    end
                end
                if (!scan_more && !pend_reg)
                begin
                    if (!found_reg)
                    begin
                        used_next = evict_reg ? cap_eff_reg : used_reg + CNT_W'(1);
                    end
                    if (op_reg == lkv_pkg::OP_GET)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
        end
    end

    // Item and scan results
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        evict_reg      <= evict_next;
        evict_rank_reg <= evict_rank_next;
        cap_eff_reg    <= cap_eff_next;
        pend_idx_reg   <= pend_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_rank_reg   <= hit_rank_next;
        hit_value_reg  <= hit_value_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
    end

endmodule

>>> rtl/core/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache, LRU replacement
// Top level: configuration port, sequencer, slot store and result register.
// ----------------------------------------------------------------------------
// One request is handled at a time. A get that misses takes one read sweep of
// the slot store; a get that hits and any put take a read sweep to match the
// key and a second read-modify-write sweep to age ranks, evict and insert. The
// sweeps come from the single read port of the slot memories and the one
// shared key comparator. req_ready is high only while idle. A get result sits
// in an output register, so the next request is taken while it waits. Valid
// bits clear at reset, so no clearing pass is needed. capacity_in_use (address
// 0) resets to 16; zero acts as one and values above ENTRIES act as ENTRIES.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int ENTRIES = lkv_pkg::LKV_ENTRIES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lkv_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lkv_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lkv_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    // Request channel
    input  logic                             req_valid,
    output logic                             req_ready,
    input  lkv_pkg::req_item_t               req,
    // Result channel
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output lkv_pkg::rsp_item_t               rsp
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic [lkv_pkg::CAP_W-1:0] cap_reg;
    logic                      rsp_valid_reg;
    lkv_pkg::rsp_item_t        rsp_reg;

    logic                      reg_sel;
    logic                      res_valid;
    logic                      res_ready;
    lkv_pkg::rsp_item_t        res;

    lkv_pkg::store_ctl_t       ctl;
    logic [IDX_W-1:0]          rd_addr;
    logic [IDX_W-1:0]          wr_addr;
    logic [lkv_pkg::KEY_W-1:0] wr_key;
    logic [lkv_pkg::VAL_W-1:0] wr_value;
    logic [IDX_W-1:0]          wr_rank;
    logic [lkv_pkg::KEY_W-1:0] rd_key;
    logic [lkv_pkg::VAL_W-1:0] rd_value;
    logic [IDX_W-1:0]          rd_rank;
    logic                      rd_valid;

    // Register decode
    assign reg_sel = paddr[lkv_pkg::APB_ADDR_W-1:2] == lkv_pkg::REG_CAPACITY;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? lkv_pkg::APB_DATA_W'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lkv_pkg::CAP_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            cap_reg <= pwdata[lkv_pkg::CAP_W-1:0];
        end
    end

    // Sequencer
    lkv_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .capacity   (cap_reg),
        .item_valid (req_valid),
        .item_ready (req_ready),
        .item       (req),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .ctl        (ctl),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .wr_key     (wr_key),
        .wr_value   (wr_value),
        .wr_rank    (wr_rank),
        .rd_key     (rd_key),
        .rd_value   (rd_value),
        .rd_rank    (rd_rank),
        .rd_valid   (rd_valid)
    );

    // Slot store
    lkv_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key),
        .wr_value (wr_value),
        .wr_rank  (wr_rank),
        .rd_key   (rd_key),
        .rd_value (rd_value),
        .rd_rank  (rd_rank),
        .rd_valid (rd_valid)
    );

    // Result register: loads when empty or draining this cycle
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
